// ===== rtl/hbw_pkg.sv =====
// shared constants and controller/datapath interface types of the heartbeat watchdog
`default_nettype none

package hbw_pkg;

  // default slot count, and the upper limit of the slot count parameter
  localparam int unsigned CLIENTS_DEF = 16;
  localparam int unsigned CLIENTS_MAX = 64;

  // field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CID_W   = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // register reset values
  localparam logic [TIME_W-1:0]  TIMEOUT_RST  = 32'd15000;
  localparam logic [TIME_W-1:0]  DEAD_MAN_RST = 32'd60000;
  localparam logic [COUNT_W-1:0] BUDGET_RST   = 8'd3;
  localparam logic [CID_W-1:0]   SELF_RST     = 4'd0;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_MAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SELF     = 2'd3;

  // item mode codes
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

  // commands from the controller
  typedef struct packed {
    logic cap;       // capture the accepted item
    logic rd_en;     // read the slot memory
    logic rep_wr;    // apply a report to the captured client
    logic scan_adv;  // finish the scanned slot, emit its event if any
    logic done_ld;   // emit the tick-done item
  } hbw_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic cid_ok;    // incoming client id addresses a real slot
    logic ev_need;   // scanned slot produces an event
    logic out_free;  // output register can take an item this cycle
  } hbw_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hbw_ctrl.sv =====
// sequencer for reports and tick scans of the heartbeat watchdog
`default_nettype none

module hbw_ctrl import hbw_pkg::*; #(
  parameter int unsigned CLIENTS = CLIENTS_DEF,
  localparam int unsigned IW = $clog2(CLIENTS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          mode_i,
  input  wire logic [CID_W-1:0] client_id_i,
  input  wire hbw_sts_t      sts_i,
  output hbw_cmd_t           cmd_o,
  output logic [IW-1:0]      rd_addr_o,
  output logic [IW-1:0]      slot_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [IW-1:0] LAST_SLOT = IW'(CLIENTS - 1);

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] idx_inc;

  assign idx_inc    = IW'(idx_q + 1'b1);
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_o     = idx_q;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o     = '0;
    rd_addr_o = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          if (mode_i == MODE_REPORT) begin
            if (sts_i.cid_ok) begin
              cmd_o.rd_en = 1'b1;
              rd_addr_o   = IW'(client_id_i);
              state_d     = S_REP;
            end
          end else begin
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = '0;
            idx_d       = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_REP: begin
        cmd_o.rep_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_SCAN: begin
        // hold the slot while its event waits for the output register
        if (!sts_i.ev_need || sts_i.out_free) begin
          cmd_o.scan_adv = 1'b1;
          if (idx_q == LAST_SLOT) begin
            state_d = S_DONE;
          end else begin
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = idx_inc;
            idx_d       = idx_inc;
          end
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done_ld = 1'b1;
          state_d       = S_IDLE;
        end
      end
    endcase
  end

  // state and slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hbw_dp.sv =====
// registers, slot memory, silence compare and output register of the heartbeat watchdog
`default_nettype none

module hbw_dp import hbw_pkg::*; #(
  parameter int unsigned CLIENTS = CLIENTS_DEF,
  localparam int unsigned IW = $clog2(CLIENTS)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [TIME_W-1:0]    cfg_data_i,
  input  wire logic [CID_W-1:0]     client_id_i,
  input  wire logic [TIME_W-1:0]    now_time_i,
  input  wire logic                 report_healthy_i,
  input  wire hbw_cmd_t             cmd_i,
  input  wire logic [IW-1:0]        rd_addr_i,
  input  wire logic [IW-1:0]        slot_i,
  output hbw_sts_t                  sts_o,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output logic [CID_W-1:0]          event_client_o,
  output logic [KIND_W-1:0]         event_kind_o,
  output logic [COUNT_W-1:0]        attempt_count_o,
  output logic                      last_of_run_o
);

  localparam int unsigned MW = COUNT_W + TIME_W;
  localparam int unsigned CW = (IW > CID_W) ? IW : CID_W;
  localparam logic [CLIENTS-1:0] HEALTHY_RST = CLIENTS'(1) << SELF_RST;

  // configuration registers
  logic [TIME_W-1:0]  timeout_q, dead_man_q;
  logic [COUNT_W-1:0] budget_q;
  logic [CID_W-1:0]   self_q;

  // captured item
  logic [CID_W-1:0]  cid_q;
  logic [TIME_W-1:0] now_q;
  logic              rh_q;

  // slot state: {restart count, last seen} in memory, flags in flops
  logic [MW-1:0]      mem_q [CLIENTS];
  logic [CLIENTS-1:0] vld_q;
  logic [CLIENTS-1:0] healthy_q;
  logic [MW-1:0]      rd_data_q;
  logic               rd_vld_q;

  // output register
  logic               out_valid_q;
  logic [CID_W-1:0]   ev_client_q;
  logic [KIND_W-1:0]  ev_kind_q;
  logic [COUNT_W-1:0] ev_count_q;
  logic               ev_last_q;

  logic [IW-1:0]      cid_addr;
  logic [TIME_W-1:0]  ls_rd;
  logic [COUNT_W-1:0] cnt_rd, cnt_inc, rep_cnt;
  logic [TIME_W-1:0]  silence;
  logic               is_self, active, dead, tmo, ev, refused;
  logic               we, out_ld, out_free;
  logic [IW-1:0]      wa;
  logic [MW-1:0]      wd;
  logic [KIND_W-1:0]  ev_kind;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TIMEOUT_RST;
      dead_man_q <= DEAD_MAN_RST;
      budget_q   <= BUDGET_RST;
      self_q     <= SELF_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TIMEOUT:  timeout_q  <= cfg_data_i;
        REG_DEAD_MAN: dead_man_q <= cfg_data_i;
        REG_BUDGET:   budget_q   <= cfg_data_i[COUNT_W-1:0];
        REG_SELF:     self_q     <= cfg_data_i[CID_W-1:0];
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cid_q <= client_id_i;
      now_q <= now_time_i;
      rh_q  <= report_healthy_i;
    end
  end

  assign cid_addr     = IW'(cid_q);
  assign sts_o.cid_ok = (32'(client_id_i) < 32'(CLIENTS));

  // entry never written reads as zero
  assign ls_rd   = rd_vld_q ? rd_data_q[TIME_W-1:0] : '0;
  assign cnt_rd  = rd_vld_q ? rd_data_q[MW-1:TIME_W] : '0;
  assign cnt_inc = COUNT_W'(cnt_rd + 1'b1);

  // scanned slot evaluation
  assign silence = now_q - ls_rd;
  assign is_self = (CW'(slot_i) == CW'(self_q));
  assign active  = healthy_q[slot_i] && !is_self;
  assign dead    = (silence > dead_man_q);
  assign tmo     = (silence > timeout_q);
  assign ev      = active && (dead || tmo);
  assign refused = (cnt_rd >= budget_q);
  assign sts_o.ev_need = ev;

  always_comb begin
    if (!dead) begin
      ev_kind = KIND_TIMEOUT;
    end else if (refused) begin
      ev_kind = KIND_REFUSED;
    end else begin
      ev_kind = KIND_RESTART;
    end
  end

  // report clears the count when an unhealthy client comes back healthy
  assign rep_cnt = (!healthy_q[cid_addr] && rh_q) ? '0 : cnt_rd;

  // memory write port
  assign we = cmd_i.rep_wr || (cmd_i.scan_adv && ev && dead && !refused);
  assign wa = cmd_i.rep_wr ? cid_addr : slot_i;
  assign wd = cmd_i.rep_wr ? {rep_cnt, now_q} : {cnt_inc, ls_rd};

  // slot memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // written marks, read mark and health flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      healthy_q <= HEALTHY_RST;
    end else begin
      if (we) begin
        vld_q[wa] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
      if (cmd_i.rep_wr) begin
        healthy_q[cid_addr] <= rh_q;
      end else if (cmd_i.scan_adv && ev) begin
        healthy_q[slot_i] <= 1'b0;
      end
    end
  end

  // output register
  assign out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.out_free = out_free;
  assign out_ld         = (cmd_i.scan_adv && ev) || cmd_i.done_ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done_ld) begin
      ev_client_q <= '0;
      ev_kind_q   <= KIND_DONE;
      ev_count_q  <= '0;
      ev_last_q   <= 1'b1;
    end else if (out_ld) begin
      ev_client_q <= CID_W'(slot_i);
      ev_kind_q   <= ev_kind;
      ev_count_q  <= (dead && !refused) ? cnt_inc : cnt_rd;
      ev_last_q   <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_client_o  = ev_client_q;
  assign event_kind_o    = ev_kind_q;
  assign attempt_count_o = ev_count_q;
  assign last_of_run_o   = ev_last_q;

endmodule

`default_nettype wire

// ===== rtl/multi_client_heartbeat_watchdog.sv =====
// A report is accepted, then its slot memory entry is updated; it gives no result.
// A tick scans one slot a cycle through the single memory read port while no event waits
// on a stalled output; after the last slot the tick-done item goes into the output register
// and the block returns to idle, ready for the next item. One item is in work at
// a time; an event waiting on a stalled output holds the scan. Reset (async, active low)
// restores register defaults, marks slots unwritten (read as zero), self slot healthy.
`default_nettype none

module multi_client_heartbeat_watchdog import hbw_pkg::*; #(
  parameter int unsigned CLIENTS = CLIENTS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 mode_i,
  input  wire logic [CID_W-1:0]     client_id_i,
  input  wire logic [TIME_W-1:0]    now_time_i,
  input  wire logic                 report_healthy_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [CID_W-1:0]          event_client_o,
  output logic [KIND_W-1:0]         event_kind_o,
  output logic [COUNT_W-1:0]        attempt_count_o,
  output logic                      last_of_run_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [TIME_W-1:0]    cfg_data_i
);

  localparam int unsigned IW = $clog2(CLIENTS);

  hbw_cmd_t      cmd;
  hbw_sts_t      sts;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] slot;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  // sequencer
  hbw_ctrl #(
    .CLIENTS (CLIENTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .client_id_i (client_id_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .slot_o      (slot)
  );

  // datapath
  hbw_dp #(
    .CLIENTS (CLIENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .client_id_i      (client_id_i),
    .now_time_i       (now_time_i),
    .report_healthy_i (report_healthy_i),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .slot_i           (slot),
    .sts_o            (sts),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .event_client_o   (event_client_o),
    .event_kind_o     (event_kind_o),
    .attempt_count_o  (attempt_count_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== rtl/hbw_checker.sv =====
// port-level checks of the heartbeat watchdog and their binding to the top level
`default_nettype none

module hbw_checker import hbw_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 mode_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [CID_W-1:0]     event_client_o,
  input wire logic [KIND_W-1:0]    event_kind_o,
  input wire logic [COUNT_W-1:0]   attempt_count_o,
  input wire logic                 last_of_run_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_client_o) &&
      $stable(event_kind_o) && $stable(attempt_count_o) && $stable(last_of_run_o))
    else $error("result item changed while stalled");

  // the run marker goes only with a clean tick-done item
  a_done_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |-> event_kind_o == KIND_DONE &&
      event_client_o == '0 && attempt_count_o == '0)
    else $error("malformed tick-done item");

  // every tick-done item closes a run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == KIND_DONE |-> last_of_run_o)
    else $error("tick-done item without run marker");

  // a granted restart has counted at least one attempt
  a_restart_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == KIND_RESTART |-> attempt_count_o != '0)
    else $error("restart item with zero attempts");

  // an accepted tick blocks the input while the scan runs
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == MODE_TICK |=> in_stall_o)
    else $error("input open right after a tick item");

endmodule

bind multi_client_heartbeat_watchdog hbw_checker u_hbw_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench: heartbeat watchdog against an in-bench prediction of its events
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hbw_pkg::*;

  localparam int unsigned NUM_SLOTS = CLIENTS_DEF;
  localparam int unsigned RUN_LIMIT = 400000;
  localparam int unsigned QUIET_CYCLES = 2 * NUM_SLOTS + 8;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 24;

  typedef struct {
    logic               mode;
    logic [CID_W-1:0]   client;
    logic [TIME_W-1:0]  stamp;
    logic               healthy;
  } beat_item_t;

  typedef struct {
    logic [CID_W-1:0]   client;
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] attempts;
    logic               last;
  } wd_event_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i = MODE_TICK;
  logic [CID_W-1:0]     client_id_i = '0;
  logic [TIME_W-1:0]    now_time_i = '0;
  logic                 report_healthy_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CID_W-1:0]     event_client_o;
  logic [KIND_W-1:0]    event_kind_o;
  logic [COUNT_W-1:0]   attempt_count_o;
  logic                 last_of_run_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_TIMEOUT;
  logic [TIME_W-1:0]    cfg_data_i = '0;

  multi_client_heartbeat_watchdog #(.CLIENTS(NUM_SLOTS)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .client_id_i     (client_id_i),
    .now_time_i      (now_time_i),
    .report_healthy_i(report_healthy_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_client_o  (event_client_o),
    .event_kind_o    (event_kind_o),
    .attempt_count_o (attempt_count_o),
    .last_of_run_o   (last_of_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // watchdog shadow state and registers
  logic [TIME_W-1:0]  seen_at [NUM_SLOTS];
  logic               slot_healthy [NUM_SLOTS];
  logic [COUNT_W-1:0] slot_tries [NUM_SLOTS];
  logic [TIME_W-1:0]  wd_timeout = TIMEOUT_RST;
  logic [TIME_W-1:0]  wd_dead_man = DEAD_MAN_RST;
  logic [COUNT_W-1:0] wd_budget = BUDGET_RST;
  logic [CID_W-1:0]   wd_self = SELF_RST;

  beat_item_t  beat_queue[$];
  wd_event_t   expected_events[$];

  logic        item_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned items_in = 0;
  int unsigned ticks_in = 0;
  int unsigned events_checked = 0;
  int unsigned settings_used = 1;
  int unsigned kind_seen [4] = '{0, 0, 0, 0};
  logic [TIME_W-1:0] cur_time;

  // per-phase register settings, input idling, output stalling and time scale
  logic [TIME_W-1:0]  ph_timeout [PHASES] = '{32'd15000, 32'd100, 32'd0, 32'hFFFF_FFFF,
                                              32'd5000, 32'd1000, 32'hFFFF_FFFF, 32'd15000};
  logic [TIME_W-1:0]  ph_dead_man [PHASES] = '{32'd60000, 32'd400, 32'd0, 32'hFFFF_FFFF,
                                               32'd2000, 32'hFFFF_FFFF, 32'd3000, 32'd60000};
  logic [COUNT_W-1:0] ph_budget [PHASES] = '{8'd3, 8'd1, 8'd0, 8'd255, 8'd1, 8'd255, 8'd0, 8'd3};
  logic [CID_W-1:0]   ph_self [PHASES] = '{4'd0, 4'd15, 4'd7, 4'd3, 4'd0, 4'd9, 4'd12, 4'd0};
  int unsigned ph_scale [PHASES] = '{80000, 600, 50, 1000000, 8000, 3000, 6000, 80000};
  int unsigned ph_send [PHASES] = '{0, 63, 0, 26, 0, 63, 0, 26};
  int unsigned ph_recv [PHASES] = '{0, 0, 63, 26, 0, 0, 63, 26};

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("%0t run limit of %0d cycles reached", $realtime, RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // shadow state after reset
  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      seen_at[i] = '0;
      slot_healthy[i] = (i == SELF_RST);
      slot_tries[i] = '0;
    end
  end

  // apply one accepted item, queue the events a tick gives
  function automatic void predict_watchdog_events(beat_item_t it);
    logic [TIME_W-1:0] silence;
    wd_event_t ev;
    if (it.mode == MODE_REPORT) begin
      // a report for a slot that does not exist is dropped
      if (32'(it.client) >= NUM_SLOTS) return;
      if (!slot_healthy[it.client] && it.healthy && slot_tries[it.client] != 0)
        slot_tries[it.client] = '0;
      seen_at[it.client] = it.stamp;
      slot_healthy[it.client] = it.healthy;
      return;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (i != wd_self && slot_healthy[i]) begin
        silence = it.stamp - seen_at[i];
        ev.client = CID_W'(i);
        ev.last = 1'b0;
        if (silence > wd_dead_man) begin
          slot_healthy[i] = 1'b0;
          if (slot_tries[i] >= wd_budget) begin
            ev.kind = KIND_REFUSED;
          end else begin
            slot_tries[i] = COUNT_W'(slot_tries[i] + 1'b1);
            ev.kind = KIND_RESTART;
          end
          ev.attempts = slot_tries[i];
          expected_events.push_back(ev);
        end else if (silence > wd_timeout) begin
          slot_healthy[i] = 1'b0;
          ev.kind = KIND_TIMEOUT;
          ev.attempts = slot_tries[i];
          expected_events.push_back(ev);
        end
      end
    end
    ev.client = '0;
    ev.kind = KIND_DONE;
    ev.attempts = '0;
    ev.last = 1'b1;
    expected_events.push_back(ev);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      errors++;
    end
  endtask

  // item driver, inputs change on the falling edge
  always @(negedge clk_i) begin : drive_items
    beat_item_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = beat_queue.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= nxt.mode;
          client_id_i <= nxt.client;
          now_time_i <= nxt.stamp;
          report_healthy_i <= nxt.healthy;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: input acceptance feeds the prediction, output items are checked
  always @(posedge clk_i) begin : watch_ports
    wd_event_t ev;
    if (rst_ni) begin
      item_taken = in_valid_i && !in_stall_o;
      if (item_taken) begin
        predict_watchdog_events(beat_item_t'{mode_i, client_id_i, now_time_i,
                                             report_healthy_i});
        items_in++;
        if (mode_i == MODE_TICK) ticks_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $display("%0t unexpected event: client %0h kind %0h attempts %0h last %0b",
                   $realtime, event_client_o, event_kind_o, attempt_count_o, last_of_run_o);
          errors++;
        end else begin
          ev = expected_events.pop_front();
          check_field("event_client", 32'(ev.client), 32'(event_client_o));
          check_field("event_kind", 32'(ev.kind), 32'(event_kind_o));
          check_field("attempt_count", 32'(ev.attempts), 32'(attempt_count_o));
          check_field("last_of_run", 32'(ev.last), 32'(last_of_run_o));
          kind_seen[ev.kind]++;
          events_checked++;
        end
      end
    end
  end

  task automatic queue_item(logic mode, logic [CID_W-1:0] client, logic [TIME_W-1:0] stamp,
                            logic healthy);
    beat_item_t it;
    it.mode = mode;
    it.client = client;
    it.stamp = stamp;
    it.healthy = healthy;
    beat_queue.push_back(it);
  endtask

  // a burst of reports then a tick at some later time, or now and then one random item
  task automatic queue_round(input int unsigned scale, inout int unsigned queued);
    int unsigned reps;
    if ($urandom_range(7) == 0) begin
      queue_item(1'($urandom_range(1)), CID_W'($urandom_range(15)), $urandom(),
                 1'($urandom_range(1)));
      queued++;
    end else begin
      reps = $urandom_range(6, 1);
      repeat (reps) begin
        cur_time += $urandom_range(scale / 8);
        queue_item(MODE_REPORT, CID_W'($urandom_range(NUM_SLOTS - 1)), cur_time,
                   $urandom_range(9) != 0);
      end
      cur_time += $urandom_range(scale * 2);
      queue_item(MODE_TICK, CID_W'($urandom_range(15)), cur_time, 1'($urandom_range(1)));
      queued += reps + 1;
    end
  endtask

  // register write while the block is idle; upper data bits of narrow registers are noise
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
    logic [TIME_W-1:0] data;
    data = value;
    if (idx == REG_BUDGET) data[TIME_W-1:COUNT_W] = (TIME_W - COUNT_W)'($urandom());
    if (idx == REG_SELF) data[TIME_W-1:CID_W] = (TIME_W - CID_W)'($urandom());
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TIMEOUT:  wd_timeout = data;
      REG_DEAD_MAN: wd_dead_man = data;
      REG_BUDGET:   wd_budget = data[COUNT_W-1:0];
      default:      wd_self = data[CID_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every item to go in and every event to come out, then let the block settle
  task automatic settle();
    while (beat_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // stimulus
  initial begin : stimulus
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
    int unsigned queued;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, wrap of the clock, exact limits, restart and count clearing
    t0 = 32'hFFFF_F000;
    t1 = t0 + 32'd20000;
    t2 = t1 + 32'd70000;
    queue_item(MODE_TICK, 4'hF, 32'd0, 1'b1);
    queue_item(MODE_REPORT, 4'd1, t0, 1'b1);
    queue_item(MODE_REPORT, 4'd2, t0, 1'b1);
    queue_item(MODE_REPORT, 4'd3, t0, 1'b1);
    queue_item(MODE_REPORT, 4'd15, t0, 1'b0);
    queue_item(MODE_REPORT, 4'd0, t0, 1'b1);
    queue_item(MODE_TICK, 4'd0, t0 + 32'd15000, 1'b0);
    queue_item(MODE_TICK, 4'd0, t0 + 32'd15001, 1'b0);
    queue_item(MODE_REPORT, 4'd1, t1, 1'b1);
    queue_item(MODE_REPORT, 4'd2, t1, 1'b1);
    queue_item(MODE_REPORT, 4'd14, t1, 1'b1);
    queue_item(MODE_TICK, 4'd0, t1 + 32'd60001, 1'b0);
    queue_item(MODE_REPORT, 4'd1, t2, 1'b0);
    queue_item(MODE_REPORT, 4'd1, t2, 1'b1);
    queue_item(MODE_REPORT, 4'd2, t2, 1'b1);
    queue_item(MODE_TICK, 4'd0, t2 + 32'd60000, 1'b0);
    queue_item(MODE_REPORT, 4'd15, 32'hFFFF_FFFF, 1'b1);
    queue_item(MODE_REPORT, 4'd14, 32'hFFFF_FFFF, 1'b1);
    queue_item(MODE_TICK, 4'd0, 32'd0, 1'b0);
    queue_item(MODE_TICK, 4'd0, 32'hFFFF_FFFF, 1'b1);
    settle();

    // random rounds over several register settings, idling and output stall patterns
    cur_time = 32'hFFFE_0000;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_TIMEOUT, ph_timeout[p]);
      write_reg(REG_DEAD_MAN, ph_dead_man[p]);
      write_reg(REG_BUDGET, ph_budget[p]);
      write_reg(REG_SELF, ph_self[p]);
      settings_used++;
      send_idle_pct = ph_send[p];
      recv_stall_pct = ph_recv[p];
      queued = 0;
      while (queued < PHASE_ITEMS) queue_round(ph_scale[p], queued);
      settle();
    end

    $display("covered %0d items (%0d ticks) under %0d register settings, %0d events checked",
             items_in, ticks_in, settings_used, events_checked);
    $display("events by kind: done %0d, timeout %0d, restart %0d, refused %0d",
             kind_seen[KIND_DONE], kind_seen[KIND_TIMEOUT], kind_seen[KIND_RESTART],
             kind_seen[KIND_REFUSED]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
